[rtl/assert_macros.svh]
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

[rtl/tpf_pkg.sv]
// Shared types and constants of the tagged pose buffer
`timescale 1ns / 1ps
package tpf_pkg;
	localparam int DEPTH = 16;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	// record: tag 32, time 48, six 64-bit words
	localparam int REC_W = 32 + 48 + 6 * 64;

	typedef enum logic [2:0] {
		OP_PUSH = 3'd0, OP_POP = 3'd1, OP_TAKE = 3'd2,
		OP_PURGE = 3'd3, OP_CLEAR = 3'd4, OP_ALLOC = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PUSH, ST_POPRD, ST_SRCH, ST_SRCHW, ST_SHRD, ST_SHWR,
		ST_PURGE, ST_PURGEW, ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic          ld_in;     // capture input item
		logic          wr_push;   // write input record at tail
		logic          rd_en;     // read slot at rd_pos
		logic [AW-1:0] rd_pos;    // position from head
		logic          wr_cp;     // write read record at wr_pos
		logic [AW-1:0] wr_pos;
		logic          emit;      // latch read record into result
		logic          drop_head;
		logic          dec_count;
		logic          clr;
		logic          alloc;
		logic          purge_inc;
		logic          set_drop;
		logic          out_ld;    // result valid
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t           op;
		logic [CW-1:0] count;
		logic          tag_match; // read record tag equals searched tag
		logic          expired;   // read record is older than timeout
	} sts_t;
endpackage

[rtl/tpf_ram.sv]
// Generic single port write, registered read RAM
`timescale 1ns / 1ps
module tpf_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/tpf_ctrl.sv]
// Operation sequencer of the tagged pose buffer
`timescale 1ns / 1ps
module tpf_ctrl import tpf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;
	logic [AW-1:0] pos_q, pos_d;
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pos_q <= pos_d;
			if (cmd.out_ld) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	assign out_valid = ov_q;
	// accept a new item only when idle and the result slot is free or draining
	assign in_stall = (state_q != ST_IDLE) || (ov_q && out_stall);

	always_comb begin
		state_d = state_q;
		pos_d = pos_q;
		cmd = '0;
		cmd.rd_pos = pos_q;
		cmd.wr_pos = pos_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.ld_in = 1'b1;
					pos_d = '0;
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// dispatch on captured opcode
				case (sts.op)
					OP_PUSH: begin
						if (sts.count == CW'(DEPTH)) begin
							cmd.drop_head = 1'b1;
							cmd.set_drop = 1'b1;
						end
						cmd.wr_push = 1'b1;
						state_d = ST_DONE;
					end
					OP_POP: begin
						if (sts.count != '0) begin
							cmd.rd_en = 1'b1;
							state_d = ST_POPRD;
						end else state_d = ST_DONE;
					end
					OP_TAKE: begin
						if (sts.count != '0) begin
							cmd.rd_en = 1'b1;
							state_d = ST_SRCH;
						end else state_d = ST_DONE;
					end
					OP_PURGE: begin
						if (sts.count != '0) begin
							cmd.rd_en = 1'b1;
							state_d = ST_PURGE;
						end else state_d = ST_DONE;
					end
					OP_CLEAR: begin
						cmd.clr = 1'b1;
						state_d = ST_DONE;
					end
					OP_ALLOC: begin
						cmd.alloc = 1'b1;
						state_d = ST_DONE;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_POPRD: begin
				cmd.emit = 1'b1;
				cmd.drop_head = 1'b1;
				state_d = ST_DONE;
			end
			ST_SRCH: begin
				// read data of position pos_q is valid now
				if (sts.tag_match) begin
					cmd.emit = 1'b1;
					if ({1'b0, pos_q} + 1'b1 < sts.count) begin
						cmd.rd_pos = pos_q + 1'b1;
						cmd.rd_en = 1'b1;
						state_d = ST_SHWR;
					end else begin
						cmd.dec_count = 1'b1;
						state_d = ST_DONE;
					end
				end else if ({1'b0, pos_q} + 1'b1 < sts.count) begin
					pos_d = pos_q + 1'b1;
					cmd.rd_pos = pos_q + 1'b1;
					cmd.rd_en = 1'b1;
					state_d = ST_SRCHW;
				end else state_d = ST_DONE;
			end
			ST_SRCHW: state_d = ST_SRCH;
			ST_SHWR: begin
				// record at pos_q+1 is read: move it down one place
				cmd.wr_cp = 1'b1;
				pos_d = pos_q + 1'b1;
				if ({1'b0, pos_q} + 2'd2 < sts.count) begin
					cmd.rd_pos = pos_q + 2'd2;
					cmd.rd_en = 1'b1;
					state_d = ST_SHRD;
				end else begin
					cmd.dec_count = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_SHRD: begin
				// keep the read on the record that moves next
				cmd.rd_pos = pos_q + 1'b1;
				cmd.rd_en = 1'b1;
				state_d = ST_SHWR;
			end
			ST_PURGE: begin
				if (sts.expired) begin
					cmd.drop_head = 1'b1;
					cmd.purge_inc = 1'b1;
					if (sts.count > CW'(1)) begin
						cmd.rd_pos = AW'(1);
						cmd.rd_en = 1'b1;
						state_d = ST_PURGEW;
					end else state_d = ST_DONE;
				end else state_d = ST_DONE;
			end
			ST_PURGEW: state_d = ST_PURGE;
			ST_DONE: begin
				cmd.out_ld = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[rtl/tpf_dp.sv]
// Record storage, pointers and result registers
`timescale 1ns / 1ps
module tpf_dp import tpf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [2:0]   opcode,
	input  logic [31:0]  frame_id,
	input  logic [47:0]  timestamp_ms,
	input  logic [63:0]  pos_x,
	input  logic [63:0]  pos_y,
	input  logic [63:0]  pos_z,
	input  logic [63:0]  rot_x,
	input  logic [63:0]  rot_y,
	input  logic [63:0]  rot_z,
	input  logic [47:0]  now_ms,
	input  logic [31:0]  timeout_q,
	input  cmd_t         cmd,
	output sts_t         sts,
	output logic         found,
	output logic [31:0]  out_frame_id,
	output logic [47:0]  out_timestamp_ms,
	output logic [63:0]  out_pos_x,
	output logic [63:0]  out_pos_y,
	output logic [63:0]  out_pos_z,
	output logic [63:0]  out_rot_x,
	output logic [63:0]  out_rot_y,
	output logic [63:0]  out_rot_z,
	output logic [4:0]   occupancy,
	output logic         dropped_oldest,
	output logic         purged_count_unused,
	output logic [4:0]   purged_count
);
	logic [2:0]       op_q;
	logic [31:0]      tag_q;
	logic [47:0]      now_q;
	logic [REC_W-1:0] in_rec_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [31:0]      next_tag_q;
	logic [CW-1:0]    purge_q;
	logic             drop_q;
	logic [REC_W-1:0] rd_rec;
	logic [REC_W-1:0] res_q;
	logic             found_q;
	logic             alloc_q;
	logic [31:0]      alloc_tag_q;
	logic             we;
	logic [AW-1:0]    waddr, raddr, head_eff;
	logic [REC_W-1:0] wdata;
	logic [47:0]      age;

	// input capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			op_q <= opcode;
			tag_q <= frame_id;
			now_q <= now_ms;
			in_rec_q <= {frame_id, timestamp_ms, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z};
		end
		if (cmd.emit) res_q <= rd_rec;
		if (cmd.alloc) alloc_tag_q <= next_tag_q;
	end

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] p);
		logic [AW:0] s;
		s = {1'b0, h} + {1'b0, p};
		slot = (s >= (AW+1)'(DEPTH)) ? AW'(s - (AW+1)'(DEPTH)) : s[AW-1:0];
	endfunction

	// push after a drop uses the advanced head
	assign head_eff = cmd.drop_head ? slot(head_q, AW'(1)) : head_q;
	assign we = cmd.wr_push || cmd.wr_cp;
	assign waddr = cmd.wr_push ? slot(head_eff, AW'(cmd.drop_head ? count_q - 1'b1 : count_q))
		: slot(head_q, cmd.wr_pos);
	assign wdata = cmd.wr_push ? in_rec_q : rd_rec;
	assign raddr = slot(head_q, cmd.rd_pos);

	tpf_ram #(.W(REC_W), .D(DEPTH)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd_rec)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			count_q <= '0;
			next_tag_q <= 32'd1;
			purge_q <= '0;
			drop_q <= 1'b0;
			found_q <= 1'b0;
			alloc_q <= 1'b0;
		end else begin
			if (cmd.ld_in) begin
				purge_q <= '0;
				drop_q <= 1'b0;
				found_q <= 1'b0;
				alloc_q <= 1'b0;
			end
			if (cmd.clr) begin
				head_q <= '0;
				count_q <= '0;
			end else begin
				if (cmd.drop_head) head_q <= slot(head_q, AW'(1));
				if (cmd.wr_push && !cmd.drop_head) count_q <= count_q + 1'b1;
				else if ((cmd.drop_head && !cmd.wr_push) || cmd.dec_count)
					count_q <= count_q - 1'b1;
			end
			if (cmd.alloc) begin
				next_tag_q <= next_tag_q + 32'd1;
				alloc_q <= 1'b1;
			end
			if (cmd.purge_inc) purge_q <= purge_q + 1'b1;
			if (cmd.set_drop) drop_q <= 1'b1;
			if (cmd.emit) found_q <= 1'b1;
		end
	end

	assign age = now_q - rd_rec[REC_W-33 -: 48];
	assign sts.op = op_t'(op_q);
	assign sts.count = count_q;
	assign sts.tag_match = rd_rec[REC_W-1 -: 32] == tag_q;
	assign sts.expired = (now_q > rd_rec[REC_W-33 -: 48]) && (age > {16'd0, timeout_q});

	// result fields, zero where the operation returns nothing
	assign found = found_q;
	assign out_frame_id = found_q ? res_q[REC_W-1 -: 32] : (alloc_q ? alloc_tag_q : 32'd0);
	assign out_timestamp_ms = found_q ? res_q[REC_W-33 -: 48] : 48'd0;
	assign out_pos_x = found_q ? res_q[383:320] : 64'd0;
	assign out_pos_y = found_q ? res_q[319:256] : 64'd0;
	assign out_pos_z = found_q ? res_q[255:192] : 64'd0;
	assign out_rot_x = found_q ? res_q[191:128] : 64'd0;
	assign out_rot_y = found_q ? res_q[127:64] : 64'd0;
	assign out_rot_z = found_q ? res_q[63:0] : 64'd0;
	assign occupancy = 5'(count_q);
	assign dropped_oldest = drop_q;
	assign purged_count = 5'(purge_q);
	assign purged_count_unused = 1'b0;
endmodule

[rtl/tagged_pose_fifo_with_expiry.sv]
// Top level of the tagged pose buffer
// Ordered buffer of up to 16 pose records held in one RAM. One item is worked
// at a time; a new item is taken once the previous result is loaded into the
// output register and is leaving it, so a held-off result delays the next item.
// Push, clear, allocate, undefined codes and any operation on an empty buffer
// finish without a RAM read; pop reads the head record; purge reads and drops
// expired records from the head; take reads records until the tag matches and
// then moves each later record down one place, all through the one read port
// of the record RAM. The timeout register resets to 1000 ms.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tagged_pose_fifo_with_expiry import tpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [31:0] frame_id,
	input  logic [47:0] timestamp_ms,
	input  logic [63:0] pos_x,
	input  logic [63:0] pos_y,
	input  logic [63:0] pos_z,
	input  logic [63:0] rot_x,
	input  logic [63:0] rot_y,
	input  logic [63:0] rot_z,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] out_frame_id,
	output logic [47:0] out_timestamp_ms,
	output logic [63:0] out_pos_x,
	output logic [63:0] out_pos_y,
	output logic [63:0] out_pos_z,
	output logic [63:0] out_rot_x,
	output logic [63:0] out_rot_y,
	output logic [63:0] out_rot_z,
	output logic [4:0]  occupancy,
	output logic        dropped_oldest,
	output logic [4:0]  purged_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic [31:0] timeout_q;
	logic spare;

	// timeout register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) timeout_q <= 32'd1000;
		else if (cfg_valid && cfg_ready) timeout_q <= cfg_data;
	end

	tpf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	tpf_dp u_dp (
		.clk(clk), .arst_n(arst_n), .opcode(opcode), .frame_id(frame_id),
		.timestamp_ms(timestamp_ms), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .now_ms(now_ms),
		.timeout_q(timeout_q), .cmd(cmd), .sts(sts), .found(found),
		.out_frame_id(out_frame_id), .out_timestamp_ms(out_timestamp_ms),
		.out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
		.out_rot_x(out_rot_x), .out_rot_y(out_rot_y), .out_rot_z(out_rot_z),
		.occupancy(occupancy), .dropped_oldest(dropped_oldest),
		.purged_count_unused(spare), .purged_count(purged_count)
	);

	// checks
	`ASSERT_IMPLIES(a_occ_max, clk, arst_n, 1'b1, occupancy <= 5'd16 && !spare)
	`ASSERT_NEXT(a_ld_busy, clk, arst_n, cmd.ld_in, in_stall)
	`ASSERT_IMPLIES(a_found_drop, clk, arst_n, out_valid, !(found && dropped_oldest))
endmodule

[dv/tagged_pose_fifo_with_expiry_test.sv]
// Self-checking testbench of the tagged pose buffer with expiry
`timescale 1ns / 1ps
module tagged_pose_fifo_with_expiry_test;
	import tpf_pkg::*;

	localparam int BUF_DEPTH = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] tag;
		logic [47:0] stamp;
		logic [63:0] w [6];
		logic [47:0] now;
	} pose_cmd_t;

	typedef struct {
		logic        found;
		logic [31:0] tag;
		logic [47:0] stamp;
		logic [63:0] w [6];
		logic [4:0]  occ;
		logic        dropped;
		logic [4:0]  purged;
	} pose_res_t;

	// directed row: command plus optional hand-typed result
	typedef struct {
		pose_cmd_t cmd;
		logic      typed;
		pose_res_t res;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] opcode = '0;
	logic [31:0] frame_id = '0;
	logic [47:0] timestamp_ms = '0;
	logic [63:0] pos_x = '0, pos_y = '0, pos_z = '0, rot_x = '0, rot_y = '0, rot_z = '0;
	logic [47:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic found;
	logic [31:0] out_frame_id;
	logic [47:0] out_timestamp_ms;
	logic [63:0] out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z;
	logic [4:0] occupancy;
	logic dropped_oldest;
	logic [4:0] purged_count;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [31:0] cfg_data = '0;

	tagged_pose_fifo_with_expiry uut (.*);

	// predictor state
	logic [31:0] mdl_tag [BUF_DEPTH];
	logic [47:0] mdl_stamp [BUF_DEPTH];
	logic [63:0] mdl_w [BUF_DEPTH][6];
	int          mdl_head = 0;
	int          mdl_count = 0;
	logic [31:0] mdl_next_tag = 32'd1;
	logic [31:0] mdl_timeout = 32'd1000;

	pose_res_t pending_results [$];
	int  errors = 0;
	int  accepted_in = 0, accepted_out = 0;
	int  idle_cycles = 0;
	bit  stimulus_done = 0;
	bit  hold_receiver = 0;
	int  op_seen [8];

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int slot_at(int pos);
		return (mdl_head + pos) % BUF_DEPTH;
	endfunction

	function automatic void load_record(ref pose_res_t r, input int s);
		r.found = 1'b1;
		r.tag = mdl_tag[s];
		r.stamp = mdl_stamp[s];
		for (int k = 0; k < 6; k++) r.w[k] = mdl_w[s][k];
	endfunction

	// field-by-field comparison of two results
	function automatic bit same_res(pose_res_t a, pose_res_t b);
		bit same;
		same = (a.found === b.found) && (a.tag === b.tag) && (a.stamp === b.stamp)
			&& (a.occ === b.occ) && (a.dropped === b.dropped) && (a.purged === b.purged);
		for (int k = 0; k < 6; k++) if (a.w[k] !== b.w[k]) same = 0;
		return same;
	endfunction

	// compute the result of one command and update the buffer image
	function automatic pose_res_t predict_pose_result(pose_cmd_t c);
		pose_res_t r;
		int i, s;
		logic [47:0] ts;
		r.found = 0; r.tag = 0; r.stamp = 0; r.occ = 0; r.dropped = 0; r.purged = 0;
		for (int k = 0; k < 6; k++) r.w[k] = 0;
		case (c.op)
			OP_PUSH: begin
				if (mdl_count >= BUF_DEPTH) begin
					mdl_head = (mdl_head + 1) % BUF_DEPTH;
					mdl_count--;
					r.dropped = 1;
				end
				s = slot_at(mdl_count);
				mdl_tag[s] = c.tag;
				mdl_stamp[s] = c.stamp;
				for (int k = 0; k < 6; k++) mdl_w[s][k] = c.w[k];
				mdl_count++;
			end
			OP_POP: begin
				if (mdl_count > 0) begin
					load_record(r, mdl_head);
					mdl_head = (mdl_head + 1) % BUF_DEPTH;
					mdl_count--;
				end
			end
			OP_TAKE: begin
				for (i = 0; i < mdl_count; i++)
					if (mdl_tag[slot_at(i)] == c.tag) break;
				if (i < mdl_count) begin
					load_record(r, slot_at(i));
					for (; i + 1 < mdl_count; i++) begin
						mdl_tag[slot_at(i)] = mdl_tag[slot_at(i + 1)];
						mdl_stamp[slot_at(i)] = mdl_stamp[slot_at(i + 1)];
						for (int k = 0; k < 6; k++) mdl_w[slot_at(i)][k] = mdl_w[slot_at(i + 1)][k];
					end
					mdl_count--;
				end
			end
			OP_PURGE: begin
				while (mdl_count > 0) begin
					ts = mdl_stamp[mdl_head];
					if (c.now > ts && (c.now - ts) > {16'd0, mdl_timeout}) begin
						mdl_head = (mdl_head + 1) % BUF_DEPTH;
						mdl_count--;
						r.purged++;
					end else break;
				end
			end
			OP_CLEAR: begin
				mdl_count = 0;
				mdl_head = 0;
			end
			OP_ALLOC: begin
				r.tag = mdl_next_tag;
				mdl_next_tag = mdl_next_tag + 1;
			end
			default: ;
		endcase
		r.occ = mdl_count[4:0];
		return r;
	endfunction

	function automatic pose_cmd_t make_cmd(logic [2:0] op, logic [31:0] tag,
			logic [47:0] stamp, logic [47:0] now);
		pose_cmd_t c;
		c.op = op; c.tag = tag; c.stamp = stamp; c.now = now;
		for (int k = 0; k < 6; k++) c.w[k] = {$urandom, $urandom};
		return c;
	endfunction

	function automatic pose_res_t empty_res(logic [4:0] occ);
		pose_res_t r;
		r.found = 0; r.tag = 0; r.stamp = 0; r.occ = occ; r.dropped = 0; r.purged = 0;
		for (int k = 0; k < 6; k++) r.w[k] = 0;
		return r;
	endfunction

	// drive one command and wait for its acceptance; valid stays up until the
	// next command draws a gap or the sender pauses
	task automatic send_cmd(pose_cmd_t c, bit typed, pose_res_t typed_res);
		pose_res_t p;
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= c.op; frame_id <= c.tag; timestamp_ms <= c.stamp; now_ms <= c.now;
		pos_x <= c.w[0]; pos_y <= c.w[1]; pos_z <= c.w[2];
		rot_x <= c.w[3]; rot_y <= c.w[4]; rot_z <= c.w[5];
		do @(posedge clk); while (in_stall);
		p = predict_pose_result(c);
		if (typed && !same_res(p, typed_res)) begin
			$display("%0t: directed row op %0d exp tag %0h occ %0d got tag %0h occ %0d",
				$time, c.op, typed_res.tag, typed_res.occ, p.tag, p.occ);
			errors++;
		end
		pending_results.push_back(typed ? typed_res : p);
		op_seen[c.op]++;
		accepted_in++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_timeout(logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mdl_timeout = value;
	endtask

	// receiver: random hold-off per result, checks each against oldest expectation
	initial begin
		pose_res_t e;
		int rx_wait;
		rx_wait = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				accepted_out++;
				rx_wait = $urandom_range(0, 5);
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, occupancy %0d", $time, occupancy);
					errors++;
				end else begin
					e = pending_results.pop_front();
					if (found !== e.found) begin
						$display("%0t: found exp %0h got %0h", $time, e.found, found); errors++;
					end
					if (out_frame_id !== e.tag) begin
						$display("%0t: frame id exp %0h got %0h", $time, e.tag, out_frame_id);
						errors++;
					end
					if (out_timestamp_ms !== e.stamp) begin
						$display("%0t: timestamp exp %0h got %0h", $time, e.stamp,
							out_timestamp_ms);
						errors++;
					end
					if (out_pos_x !== e.w[0]) begin
						$display("%0t: pos_x exp %0h got %0h", $time, e.w[0], out_pos_x); errors++;
					end
					if (out_pos_y !== e.w[1]) begin
						$display("%0t: pos_y exp %0h got %0h", $time, e.w[1], out_pos_y); errors++;
					end
					if (out_pos_z !== e.w[2]) begin
						$display("%0t: pos_z exp %0h got %0h", $time, e.w[2], out_pos_z); errors++;
					end
					if (out_rot_x !== e.w[3]) begin
						$display("%0t: rot_x exp %0h got %0h", $time, e.w[3], out_rot_x); errors++;
					end
					if (out_rot_y !== e.w[4]) begin
						$display("%0t: rot_y exp %0h got %0h", $time, e.w[4], out_rot_y); errors++;
					end
					if (out_rot_z !== e.w[5]) begin
						$display("%0t: rot_z exp %0h got %0h", $time, e.w[5], out_rot_z); errors++;
					end
					if (occupancy !== e.occ) begin
						$display("%0t: occupancy exp %0d got %0d", $time, e.occ, occupancy);
						errors++;
					end
					if (dropped_oldest !== e.dropped) begin
						$display("%0t: dropped exp %0h got %0h", $time, e.dropped,
							dropped_oldest);
						errors++;
					end
					if (purged_count !== e.purged) begin
						$display("%0t: purged exp %0d got %0d", $time, e.purged, purged_count);
						errors++;
					end
				end
			end
			// next stall decision
			if (hold_receiver) out_stall <= 1'b1;
			else if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else out_stall <= 1'b0;
		end
	end

	// watchdog on cycles without any acceptance
	initial begin
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n
					|| hold_receiver)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tagged_pose_fifo_with_expiry test failed");
				$finish;
			end
		end
	end

	// long receiver hold-off while sender keeps offering pushes
	task automatic hold_receiver_burst();
		fork
			begin
				hold_receiver = 1;
				repeat (400) @(posedge clk);
				hold_receiver = 0;
			end
			for (int n = 0; n < 6; n++)
				send_cmd(make_cmd(OP_PUSH, $urandom, {$urandom, $urandom} , 0), 0,
					empty_res(0));
		join
	endtask

	// random command mix, mostly well-formed traffic on a tag pool
	function automatic pose_cmd_t random_cmd(logic [47:0] clock_ms);
		int pick;
		logic [31:0] t;
		pick = $urandom_range(0, 99);
		t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 23);
		if (pick < 45)
			return make_cmd(OP_PUSH, t, clock_ms - $urandom_range(0, 3000), 0);
		else if (pick < 60) return make_cmd(OP_POP, $urandom, $urandom, $urandom);
		else if (pick < 80) return make_cmd(OP_TAKE, t, 0, 0);
		else if (pick < 90)
			return make_cmd(OP_PURGE, 0, 0, clock_ms + $urandom_range(0, 1500));
		else if (pick < 93) return make_cmd(OP_CLEAR, 0, 0, 0);
		else if (pick < 98) return make_cmd(OP_ALLOC, 0, 0, 0);
		return make_cmd(3'(6 + $urandom_range(0, 1)), $urandom, 0, 0);
	endfunction

	initial begin
		directed_row_t rows [$];
		directed_row_t row;
		pose_cmd_t c;
		pose_res_t r;
		logic [47:0] clock_ms;
		logic [31:0] tmo_set [4];
		tmo_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2500};

		@(posedge arst_n);
		@(posedge clk);

		// directed table
		row.typed = 1; row.res = empty_res(0);
		row.cmd = make_cmd(OP_POP, 0, 0, 0); rows.push_back(row);
		row.cmd = make_cmd(OP_TAKE, 32'hFFFF_FFFF, 0, 0); rows.push_back(row);
		row.cmd = make_cmd(OP_PURGE, 0, 0, 48'hFFFF_FFFF_FFFF); rows.push_back(row);
		row.cmd = make_cmd(OP_ALLOC, 0, 0, 0); row.res.tag = 32'd1; rows.push_back(row);
		row.res = empty_res(0);
		row.cmd = make_cmd(3'd6, 0, 0, 0); rows.push_back(row);
		row.cmd = make_cmd(3'd7, 0, 0, 0); rows.push_back(row);
		row.typed = 0;
		row.cmd = make_cmd(OP_PUSH, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 0);
		for (int k = 0; k < 6; k++) row.cmd.w[k] = '1;
		rows.push_back(row);
		row.cmd = make_cmd(OP_PUSH, 0, 0, 0);
		for (int k = 0; k < 6; k++) row.cmd.w[k] = '0;
		rows.push_back(row);
		row.cmd = make_cmd(OP_PUSH, 32'd7, 48'd5000, 0); rows.push_back(row);
		// now before the stamp: not expired
		row.cmd = make_cmd(OP_PURGE, 0, 0, 48'd10); rows.push_back(row);
		row.cmd = make_cmd(OP_TAKE, 32'd7, 0, 0); rows.push_back(row);
		row.cmd = make_cmd(OP_TAKE, 32'd99, 0, 0); rows.push_back(row);
		row.cmd = make_cmd(OP_POP, 0, 0, 0); rows.push_back(row);
		for (int n = 0; n < 18; n++) begin
			row.cmd = make_cmd(OP_PUSH, n, n * 100, 0); rows.push_back(row);
		end
		row.cmd = make_cmd(OP_PURGE, 0, 0, 48'd2300); rows.push_back(row);
		row.cmd = make_cmd(OP_CLEAR, 0, 0, 0); rows.push_back(row);
		foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].res);
		wait_drained();

		// a few allocations in a row
		repeat (3) send_cmd(make_cmd(OP_ALLOC, 0, 0, 0), 0, r);
		wait_drained();

		// random phases over several timeout settings
		clock_ms = 48'd100000;
		for (int ph = 0; ph < 4; ph++) begin
			write_timeout(tmo_set[ph]);
			for (int n = 0; n < 420; n++) begin
				clock_ms = clock_ms + $urandom_range(0, 40);
				if (n == 30) hold_receiver_burst();
				c = random_cmd(clock_ms);
				// occasionally an extreme now or stamp
				if ($urandom_range(0, 30) == 0) c.now = {$urandom, $urandom};
				if ($urandom_range(0, 30) == 0) c.stamp = {$urandom, $urandom};
				send_cmd(c, 0, r);
			end
			// sender pauses until all results are back
			wait_drained();
		end

		stimulus_done = 1;
		wait_drained();
		$display("covered %0d items, %0d results: push %0d pop %0d take %0d purge %0d",
			accepted_in, accepted_out, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
		$display("clear %0d allocate %0d undefined %0d, four timeout settings", op_seen[4],
			op_seen[5], op_seen[6] + op_seen[7]);
		if (errors == 0 && pending_results.size() == 0)
			$display("tagged_pose_fifo_with_expiry test passed");
		else
			$display("tagged_pose_fifo_with_expiry test failed");
		$finish;
	end
endmodule

[files.f]
+incdir+rtl
rtl/tpf_pkg.sv
rtl/tpf_ram.sv
rtl/tpf_ctrl.sv
rtl/tpf_dp.sv
rtl/tagged_pose_fifo_with_expiry.sv
dv/tagged_pose_fifo_with_expiry_test.sv
